// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/pdc_pkg.sv =====
// ----------------------------------------------------------------------------
// PID controller package
// Field widths, codes, shared record types and saturation helpers.
// ----------------------------------------------------------------------------
package pdc_pkg;

   // field widths
   localparam int SENSE_W = 16;
   localparam int ERR_W   = SENSE_W + 1;
   localparam int DIFF1_W = ERR_W + 1;
   localparam int DIFF2_W = ERR_W + 2;
   localparam int GAIN_W  = 24;
   localparam int WORD_W  = 32;
   localparam int LIMIT_W = 31;
   localparam int WIN_W   = 17;
   localparam int PROD_W  = GAIN_W + DIFF2_W;
   localparam int SUM_W   = PROD_W + 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;

   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32'sh7FFF_FFFF);
   localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(32'sh8000_0000);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE           = 3'd0,
      CSR_GAIN_P         = 3'd1,
      CSR_GAIN_I         = 3'd2,
      CSR_GAIN_D         = 3'd3,
      CSR_LIMIT_OUTPUT   = 3'd4,
      CSR_LIMIT_INTEGRAL = 3'd5,
      CSR_DEAD_BAND      = 3'd6,
      CSR_ERROR_CEILING  = 3'd7
   } csr_index_type;

   localparam logic MODE_POSITIONAL  = 1'b0;
   localparam logic MODE_INCREMENTAL = 1'b1;
   localparam logic ACTION_STEP      = 1'b0;
   localparam logic ACTION_CLEAR     = 1'b1;

   typedef struct packed {
      logic                     mode;
      logic signed [GAIN_W-1:0] gain_p;
      logic signed [GAIN_W-1:0] gain_i;
      logic signed [GAIN_W-1:0] gain_d;
      logic [LIMIT_W-1:0]       limit_output;
      logic [LIMIT_W-1:0]       limit_integral;
      logic [WIN_W-1:0]         dead_band;
      logic [WIN_W-1:0]         error_ceiling;
   } cfg_type;

   typedef struct packed {
      logic                      action;
      logic signed [SENSE_W-1:0] measured;
      logic signed [SENSE_W-1:0] target;
   } item_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] drive;
      logic                     held;
   } result_type;

   typedef struct packed {
      logic signed [ERR_W-1:0]  last_error;
      logic signed [ERR_W-1:0]  prior_error;
      logic signed [WORD_W-1:0] integral_term;
      logic signed [WORD_W-1:0] output_accumulator;
   } state_type;

   // saturate a wide signed value to the 32-bit range
   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
      if (v > SAT_HI) begin
         return SAT_HI[WORD_W-1:0];
      end else if (v < SAT_LO) begin
         return SAT_LO[WORD_W-1:0];
      end
      return v[WORD_W-1:0];
   endfunction

   // clamp a 32-bit value to plus or minus lim
   function automatic logic signed [WORD_W-1:0] clamp_sym(input logic signed [WORD_W-1:0] v,
                                                          input logic [LIMIT_W-1:0] lim);
      logic signed [WORD_W:0] v_s;
      logic signed [WORD_W:0] hi_s;
      logic signed [WORD_W:0] lo_s;
      v_s  = (WORD_W+1)'(v);
      hi_s = $signed({2'b00, lim});
      lo_s = -hi_s;
      if (v_s > hi_s) begin
         return hi_s[WORD_W-1:0];
      end else if (v_s < lo_s) begin
         return lo_s[WORD_W-1:0];
      end
      return v;
   endfunction

endpackage

// ===== hw/rtl/pdc_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one control step or clear request.
// ----------------------------------------------------------------------------
interface pdc_req_if import pdc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      action;
   logic signed [SENSE_W-1:0] measured;
   logic signed [SENSE_W-1:0] target;

   modport source (output valid, output action, output measured, output target,
                   input ready);
   modport sink (input valid, input action, input measured, input target,
                 output ready);
endinterface

// ===== hw/rtl/pdc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one controller output.
// ----------------------------------------------------------------------------
interface pdc_rsp_if import pdc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] drive;
   logic                     held;

   modport source (output valid, output drive, output held, input ready);
   modport sink (input valid, input drive, input held, output ready);
endinterface

// ===== hw/rtl/pdc_csr.sv =====
// ----------------------------------------------------------------------------
// PID controller register file
// Holds mode, gains, clamps and the error window, written by index.
// ----------------------------------------------------------------------------
module pdc_csr import pdc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode the write into the addressed field
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_MODE:           cfg_in.mode           = csr_write_data[0];
            CSR_GAIN_P:         cfg_in.gain_p         = $signed(csr_write_data[GAIN_W-1:0]);
            CSR_GAIN_I:         cfg_in.gain_i         = $signed(csr_write_data[GAIN_W-1:0]);
            CSR_GAIN_D:         cfg_in.gain_d         = $signed(csr_write_data[GAIN_W-1:0]);
            CSR_LIMIT_OUTPUT:   cfg_in.limit_output   = csr_write_data[LIMIT_W-1:0];
            CSR_LIMIT_INTEGRAL: cfg_in.limit_integral = csr_write_data[LIMIT_W-1:0];
            CSR_DEAD_BAND:      cfg_in.dead_band      = csr_write_data[WIN_W-1:0];
            CSR_ERROR_CEILING:  cfg_in.error_ceiling  = csr_write_data[WIN_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/pdc_step.sv =====
// ----------------------------------------------------------------------------
// PID controller step
// One control step: error window, P/I/D products, saturation and clamps.
// ----------------------------------------------------------------------------
module pdc_step import pdc_pkg::*; (
   input  cfg_type    cfg,
   input  item_type   item,
   input  state_type  state_cur,
   output result_type result,
   output state_type  state_next
);

   logic signed [ERR_W-1:0]   err;
   logic [ERR_W-1:0]          mag;
   logic                      window_hold;
   logic signed [DIFF1_W-1:0] diff1;
   logic signed [DIFF2_W-1:0] diff2;
   logic signed [DIFF2_W-1:0] op_p;
   logic signed [DIFF2_W-1:0] op_d;
   logic signed [PROD_W-1:0]  mul_p;
   logic signed [PROD_W-1:0]  mul_i;
   logic signed [PROD_W-1:0]  mul_d;
   logic signed [WORD_W-1:0]  term_p;
   logic signed [WORD_W-1:0]  prod_i;
   logic signed [WORD_W-1:0]  term_d;
   logic signed [WORD_W-1:0]  i_pre;
   logic signed [WORD_W-1:0]  term_i;
   logic signed [WORD_W-1:0]  base;
   logic signed [SUM_W-1:0]   sum_raw;
   logic signed [WORD_W-1:0]  sum_sat;
   logic signed [WORD_W-1:0]  acc_new;
   logic                      incr;

   // error and its magnitude
   assign err = ERR_W'(item.target) - ERR_W'(item.measured);
   assign mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

   assign window_hold = ((cfg.error_ceiling != '0) && (mag > cfg.error_ceiling)) ||
                        ((cfg.dead_band != '0) && (mag < cfg.dead_band));

   // first and second differences of the error
   assign diff1 = DIFF1_W'(err) - DIFF1_W'(state_cur.last_error);
   assign diff2 = DIFF2_W'(err) - (DIFF2_W'(state_cur.last_error) <<< 1)
                  + DIFF2_W'(state_cur.prior_error);

   // pick multiplier operands by mode
   assign incr = (cfg.mode == MODE_INCREMENTAL);
   assign op_p = incr ? DIFF2_W'(diff1) : DIFF2_W'(err);
   assign op_d = incr ? diff2 : DIFF2_W'(diff1);

   assign mul_p = PROD_W'(cfg.gain_p) * PROD_W'(op_p);
   assign mul_i = PROD_W'(cfg.gain_i) * PROD_W'(err);
   assign mul_d = PROD_W'(cfg.gain_d) * PROD_W'(op_d);

   assign term_p = sat_word(SUM_W'(mul_p));
   assign prod_i = sat_word(SUM_W'(mul_i));
   assign term_d = sat_word(SUM_W'(mul_d));

   // integral: accumulate in positional mode, increment only in incremental mode
   assign i_pre  = incr ? prod_i
                        : sat_word(SUM_W'(state_cur.integral_term) + SUM_W'(prod_i));
   assign term_i = clamp_sym(i_pre, cfg.limit_integral);

   // output sum and clamp
   assign base    = incr ? state_cur.output_accumulator : '0;
   assign sum_raw = SUM_W'(base) + SUM_W'(term_p) + SUM_W'(term_i) + SUM_W'(term_d);
   assign sum_sat = sat_word(sum_raw);
   assign acc_new = clamp_sym(sum_sat, cfg.limit_output);

   // select result and state update
   always_comb begin
      state_next = state_cur;
      result     = '0;
      if (item.action == ACTION_CLEAR) begin
         state_next = '0;
      end else if (window_hold) begin
         result.held = 1'b1;
      end else begin
         state_next.integral_term      = term_i;
         state_next.output_accumulator = acc_new;
         state_next.prior_error        = state_cur.last_error;
         state_next.last_error         = err;
         result.drive                  = acc_new;
      end
   end

endmodule

// ===== hw/rtl/pid_position_delta_controller_core.sv =====
// ----------------------------------------------------------------------------
// PID position/delta controller core
// Positional or incremental PID in Q16.16 with error window and clamps.
// ----------------------------------------------------------------------------
// The block accepts one request per cycle while the response is not stalled:
// the request is registered at the transfer, and one pass through the step
// logic (three multipliers of 24-bit gains by operands of up to 19 bits,
// saturation, sum and clamp) updates the controller state and loads the result
// register that drives the response channel when the step fires, so the next
// request already sees the updated error history and accumulator. The rate is
// set by that single register-to-register pass; a stalled response holds the
// result register and the request register, and a new request is still taken
// while the result waits if the request register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pid_position_delta_controller_core import pdc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   pdc_req_if.sink               req_chan,
   pdc_rsp_if.source             rsp_chan,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   cfg_type    cfg;
   logic       in_valid_ff;
   item_type   in_item_ff;
   logic       out_valid_ff;
   result_type out_result_ff;
   state_type  state_ff;
   result_type step_result;
   state_type  step_state_in;
   logic       advance;
   logic       req_take;
   logic       step_fire;

   pdc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   pdc_step u_step (
      .cfg        (cfg),
      .item       (in_item_ff),
      .state_cur  (state_ff),
      .result     (step_result),
      .state_next (step_state_in)
   );

   // advance when the result register is free or being drained
   assign advance   = !out_valid_ff || rsp_chan.ready;
   assign step_fire = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take  = req_chan.valid && req_chan.ready;

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.action   <= req_chan.action;
         in_item_ff.measured <= req_chan.measured;
         in_item_ff.target   <= req_chan.target;
      end
   end

   // controller state, updated once per step
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step_fire) begin
         state_ff <= step_state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step_fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire) begin
         out_result_ff <= step_result;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.drive = out_result_ff.drive;
   assign rsp_chan.held  = out_result_ff.held;

   // checks
   `ASSERT_IMPLIES(a_held_zero, clock, reset, out_valid_ff && out_result_ff.held,
      out_result_ff.drive == '0, "held result with nonzero drive")
   `ASSERT_NEXT(a_hold_keeps_state, clock, reset, step_fire && step_result.held,
      $stable(state_ff), "window hold changed controller state")
   `ASSERT_NEXT(a_clear_zeroes, clock, reset,
      step_fire && (in_item_ff.action == ACTION_CLEAR),
      state_ff == '0, "clear left controller state nonzero")
   `ASSERT_NEXT(a_req_reg_holds, clock, reset, in_valid_ff && !advance,
      in_valid_ff && $stable(in_item_ff), "stalled request register changed")

endmodule
